>>> design/rvs_pkg.sv
// Shared types, register indexes and fixed widths of the row variance block.
`default_nettype none

package rvs_pkg;

   // Fixed field widths
   localparam int ROW_LENGTH_BITS = 13;
   localparam int RESULT_BITS     = 31;
   localparam int ROOT_IN_BITS    = 32;   // result width padded to an even count
   localparam int ROOT_BITS       = 16;   // ROOT_IN_BITS / 2
   localparam int CSR_INDEX_BITS  = 2;
   localparam int CSR_DATA_BITS   = 13;

   // Parameter defaults
   localparam int DEFAULT_MAX_ROW_LENGTH = 4096;
   localparam int DEFAULT_SAMPLE_BITS    = 16;

   // Register reset values
   localparam logic                       POPULATION_MODE_RESET = 1'b1;
   localparam logic                       TAKE_ROOT_RESET       = 1'b0;
   localparam logic [ROW_LENGTH_BITS-1:0] ROW_LENGTH_RESET      = 13'd4096;

   localparam logic [RESULT_BITS-1:0] RESULT_MAX = {RESULT_BITS{1'b1}};

   // Register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_POPULATION_MODE = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TAKE_ROOT       = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ROW_LENGTH      = 2'd2;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_DEN,
      ST_MUL_SQ,
      ST_MUL_SUM,
      ST_DIV_CHK,
      ST_DIV,
      ST_ROOT,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

>>> design/rvs_if.sv
// Valid/ready channel interfaces for samples in and row results out.
`default_nettype none

interface rvs_req_if #(
   parameter int SAMPLE_BITS = rvs_pkg::DEFAULT_SAMPLE_BITS
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface rvs_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [rvs_pkg::RESULT_BITS-1:0] result;
   logic                            undefined;

   modport source (output valid, output result, output undefined, input ready);
   modport sink   (input valid, input result, input undefined, output ready);
endinterface

`default_nettype wire

>>> design/row_variance_stddev.sv
// Row variance / standard deviation from running sum and sum of squares.
//
//   channel   dir   payload                      handshake
//   req_if    in    sample (signed Q8.8)         valid/ready
//   rsp_if    out   result (31b), undefined (1b) valid/ready
//   csr_*     in    index (2b), data (13b)       write enable only
//
// A sample that does not end a row is accumulated and intake stays open. The last
// sample of a row starts a sequencer on one shared add/subtract unit: the
// multiplies, a quotient overflow check, the restoring divide and the square root
// (when selected), then the load of the output register.
// Reset is synchronous and clears the configuration, control and accumulator registers.
// The output register holds a finished result while the next row streams in;
// a second row end waits in the last state until that register is free.
`default_nettype none

module row_variance_stddev #(
   parameter int MAX_ROW_LENGTH = rvs_pkg::DEFAULT_MAX_ROW_LENGTH,
   parameter int SAMPLE_BITS    = rvs_pkg::DEFAULT_SAMPLE_BITS
) (
   input  wire                                  clock,
   input  wire                                  reset,
   rvs_req_if.sink                              req_if,
   rvs_rsp_if.source                            rsp_if,
   input  wire                                  csr_we,
   input  wire [rvs_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  wire [rvs_pkg::CSR_DATA_BITS-1:0]     csr_data
);

   // Derived widths
   localparam int NW    = $clog2(MAX_ROW_LENGTH + 1);       // row length n
   localparam int CW    = $clog2(MAX_ROW_LENGTH);           // samples taken so far
   localparam int SUMW  = SAMPLE_BITS + CW + 1;
   localparam int SQW   = 2 * SAMPLE_BITS - 1 + CW;
   localparam int DENW  = 2 * NW;
   localparam int RESW  = rvs_pkg::RESULT_BITS;
   localparam int RQW   = rvs_pkg::ROOT_IN_BITS;
   localparam int RTW   = rvs_pkg::ROOT_BITS;
   localparam int AW    = (SQW + NW > 2 * SUMW) ? SQW + NW : 2 * SUMW;
   localparam int WW    = (AW > DENW + RESW) ? AW : DENW + RESW;
   localparam int UW    = WW + 1;
   localparam int MPW   = (NW > SUMW) ? NW : SUMW;
   localparam int SMAX  = (MPW > RESW) ? MPW : RESW;
   localparam int STW   = $clog2(SMAX);
   localparam int LBITS = rvs_pkg::ROW_LENGTH_BITS;
   localparam int LW    = (NW > LBITS) ? NW : LBITS;

   localparam logic [STW-1:0] LAST_N   = STW'(NW - 1);
   localparam logic [STW-1:0] LAST_SUM = STW'(SUMW - 1);
   localparam logic [STW-1:0] LAST_DIV = STW'(RESW - 1);
   localparam logic [STW-1:0] LAST_RT  = STW'(RTW - 1);
   localparam logic [LW-1:0]  LEN_MAX  = LW'(MAX_ROW_LENGTH);

   // Configuration registers
   logic                  pop_mode_ff;
   logic                  take_root_ff;
   logic [LBITS-1:0]      row_length_ff;

   // Accumulators
   logic [CW-1:0]         count_ff, count_in;
   logic signed [SUMW-1:0] sum_ff, sum_in;
   logic [SQW-1:0]        sq_ff, sq_in;

   // Sequencer and datapath
   rvs_pkg::state_type    state_ff, state_in;
   logic [NW-1:0]         n_ff, n_in;
   logic [NW-1:0]         d_ff, d_in;
   logic                  undef_ff, undef_in;
   logic [DENW-1:0]       den_ff, den_in;
   logic [UW-1:0]         acc_ff, acc_in;
   logic [WW-1:0]         mcand_ff, mcand_in;
   logic [MPW-1:0]        mplier_ff, mplier_in;
   logic [RESW-1:0]       quot_ff, quot_in;
   logic [RQW-1:0]        rad_ff, rad_in;
   logic [RTW-1:0]        root_ff, root_in;
   logic [STW-1:0]        step_ff, step_in;

   // Output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RESW-1:0]       result_ff, result_in;
   logic                  rsp_undef_ff, rsp_undef_in;

   // Shared unit and helpers
   logic [UW-1:0]         op_a, op_b, alu_sum;
   logic                  alu_sub, alu_ge;
   logic                  req_accept, row_end, out_free, acc_neg, saturate;
   logic                  step_last;
   logic [NW-1:0]         n_next;
   logic [LW-1:0]         len_eff;
   logic [SUMW-1:0]       sum_mag;
   logic [UW-1:0]         rem_shift, trial;
   logic [RESW-1:0]       quot_step;
   logic signed [2*SAMPLE_BITS-1:0] sq_prod;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         pop_mode_ff   <= rvs_pkg::POPULATION_MODE_RESET;
         take_root_ff  <= rvs_pkg::TAKE_ROOT_RESET;
         row_length_ff <= rvs_pkg::ROW_LENGTH_RESET;
      end else if (csr_we) begin
         case (csr_index)
            rvs_pkg::CSR_POPULATION_MODE: pop_mode_ff   <= csr_data[0];
            rvs_pkg::CSR_TAKE_ROOT:       take_root_ff  <= csr_data[0];
            rvs_pkg::CSR_ROW_LENGTH:      row_length_ff <= csr_data[LBITS-1:0];
            default: ;
         endcase
      end
   end

   // Effective row length and row-end detect
   always_comb begin
      if (row_length_ff == '0) begin
         len_eff = LW'(1);
      end else if (LW'(row_length_ff) > LEN_MAX) begin
         len_eff = LEN_MAX;
      end else begin
         len_eff = LW'(row_length_ff);
      end
   end

   assign n_next     = NW'(count_ff) + NW'(1);
   assign row_end    = LW'(n_next) >= len_eff;
   assign req_accept = req_if.valid && req_if.ready;
   assign out_free   = !rsp_valid_ff || rsp_if.ready;
   assign sq_prod    = req_if.sample * req_if.sample;
   assign sum_mag    = sum_ff[SUMW-1] ? SUMW'(-sum_ff) : SUMW'(sum_ff);
   assign acc_neg    = acc_ff[UW-1];

   // Step counter end per state
   always_comb begin
      case (state_ff)
         rvs_pkg::ST_MUL_DEN: step_last = (step_ff == LAST_N);
         rvs_pkg::ST_MUL_SQ:  step_last = (step_ff == LAST_N);
         rvs_pkg::ST_MUL_SUM: step_last = (step_ff == LAST_SUM);
         rvs_pkg::ST_DIV:     step_last = (step_ff == LAST_DIV);
         rvs_pkg::ST_ROOT:    step_last = (step_ff == LAST_RT);
         default:             step_last = 1'b0;
      endcase
   end

   // Shared add/subtract unit operand select
   assign rem_shift = {acc_ff[UW-3:0], rad_ff[RQW-1 -: 2]};
   assign trial     = UW'({root_ff, 2'b01});

   always_comb begin
      op_a    = acc_ff;
      op_b    = '0;
      alu_sub = 1'b0;
      case (state_ff)
         rvs_pkg::ST_MUL_DEN, rvs_pkg::ST_MUL_SQ: begin
            op_b = mplier_ff[0] ? UW'(mcand_ff) : '0;
         end
         rvs_pkg::ST_MUL_SUM: begin
            op_b    = mplier_ff[0] ? UW'(mcand_ff) : '0;
            alu_sub = 1'b1;
         end
         rvs_pkg::ST_DIV_CHK: begin
            op_b    = UW'(WW'(den_ff) << RESW);
            alu_sub = 1'b1;
         end
         rvs_pkg::ST_DIV: begin
            op_b    = UW'(mcand_ff);
            alu_sub = 1'b1;
         end
         rvs_pkg::ST_ROOT: begin
            op_a    = rem_shift;
            op_b    = trial;
            alu_sub = 1'b1;
         end
         default: ;
      endcase
   end

   assign alu_sum  = op_a + (alu_sub ? ~op_b : op_b) + UW'(alu_sub);
   assign alu_ge   = !alu_sum[UW-1];
   assign saturate = !acc_neg && alu_ge;
   assign quot_step = {quot_ff[RESW-2:0], alu_ge};

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rvs_pkg::ST_IDLE: begin
            if (req_accept && row_end) begin
               if (!pop_mode_ff && n_next == NW'(1)) state_in = rvs_pkg::ST_DONE;
               else state_in = rvs_pkg::ST_MUL_DEN;
            end
         end
         rvs_pkg::ST_MUL_DEN: begin
            if (step_last) state_in = rvs_pkg::ST_MUL_SQ;
         end
         rvs_pkg::ST_MUL_SQ: begin
            if (step_last) state_in = rvs_pkg::ST_MUL_SUM;
         end
         rvs_pkg::ST_MUL_SUM: begin
            if (step_last) state_in = rvs_pkg::ST_DIV_CHK;
         end
         rvs_pkg::ST_DIV_CHK: begin
            if (!saturate) state_in = rvs_pkg::ST_DIV;
            else if (take_root_ff) state_in = rvs_pkg::ST_ROOT;
            else state_in = rvs_pkg::ST_DONE;
         end
         rvs_pkg::ST_DIV: begin
            if (step_last) state_in = take_root_ff ? rvs_pkg::ST_ROOT : rvs_pkg::ST_DONE;
         end
         rvs_pkg::ST_ROOT: begin
            if (step_last) state_in = rvs_pkg::ST_DONE;
         end
         rvs_pkg::ST_DONE: begin
            if (out_free) state_in = rvs_pkg::ST_IDLE;
         end
         default: state_in = rvs_pkg::ST_IDLE;
      endcase
   end

   // Handshake outputs
   always_comb begin
      req_if.ready     = (state_ff == rvs_pkg::ST_IDLE);
      rsp_if.valid     = rsp_valid_ff;
      rsp_if.result    = result_ff;
      rsp_if.undefined = rsp_undef_ff;
   end

   // Datapath next values
   always_comb begin
      count_in     = count_ff;
      sum_in       = sum_ff;
      sq_in        = sq_ff;
      n_in         = n_ff;
      d_in         = d_ff;
      undef_in     = undef_ff;
      den_in       = den_ff;
      acc_in       = acc_ff;
      mcand_in     = mcand_ff;
      mplier_in    = mplier_ff;
      quot_in      = quot_ff;
      rad_in       = rad_ff;
      root_in      = root_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff;
      result_in    = result_ff;
      rsp_undef_in = rsp_undef_ff;

      // drop the delivered item
      if (rsp_valid_ff && rsp_if.ready) rsp_valid_in = 1'b0;

      case (state_ff)
         rvs_pkg::ST_IDLE: begin
            if (req_accept) begin
               // accumulate the sample
               sum_in   = sum_ff + SUMW'(req_if.sample);
               sq_in    = sq_ff + SQW'(sq_prod[2*SAMPLE_BITS-2:0]);
               count_in = count_ff + CW'(1);
               if (row_end) begin
                  // latch the row and set up den = n * d
                  count_in  = '0;
                  n_in      = n_next;
                  d_in      = pop_mode_ff ? n_next : NW'(count_ff);
                  undef_in  = !pop_mode_ff && n_next == NW'(1);
                  acc_in    = '0;
                  mcand_in  = pop_mode_ff ? WW'(n_next) : WW'(count_ff);
                  mplier_in = MPW'(n_next);
                  step_in   = '0;
               end
            end
         end
         rvs_pkg::ST_MUL_DEN, rvs_pkg::ST_MUL_SQ, rvs_pkg::ST_MUL_SUM: begin
            // one shift-add step (shift-subtract for the square of the sum)
            acc_in    = alu_sum;
            mcand_in  = mcand_ff << 1;
            mplier_in = mplier_ff >> 1;
            step_in   = step_ff + STW'(1);
            if (step_last) begin
               step_in = '0;
               if (state_ff == rvs_pkg::ST_MUL_DEN) begin
                  den_in    = alu_sum[DENW-1:0];
                  acc_in    = '0;
                  mcand_in  = WW'(sq_ff);
                  mplier_in = MPW'(n_ff);
               end else if (state_ff == rvs_pkg::ST_MUL_SQ) begin
                  mcand_in  = WW'(sum_mag);
                  mplier_in = MPW'(sum_mag);
               end
            end
         end
         rvs_pkg::ST_DIV_CHK: begin
            // clamp a negative numerator, test quotient overflow
            if (acc_neg) acc_in = '0;
            step_in  = '0;
            mcand_in = WW'(den_ff) << (RESW - 1);
            if (saturate) begin
               quot_in = rvs_pkg::RESULT_MAX;
               acc_in  = '0;
               rad_in  = RQW'(rvs_pkg::RESULT_MAX);
               root_in = '0;
            end else begin
               quot_in = '0;
            end
         end
         rvs_pkg::ST_DIV: begin
            // one restoring divide step
            if (alu_ge) acc_in = alu_sum;
            quot_in  = quot_step;
            mcand_in = mcand_ff >> 1;
            step_in  = step_ff + STW'(1);
            if (step_last) begin
               step_in = '0;
               acc_in  = '0;
               rad_in  = RQW'(quot_step);
               root_in = '0;
            end
         end
         rvs_pkg::ST_ROOT: begin
            // one digit-by-digit root step
            acc_in  = alu_ge ? alu_sum : rem_shift;
            root_in = {root_ff[RTW-2:0], alu_ge};
            rad_in  = rad_ff << 2;
            step_in = step_ff + STW'(1);
         end
         rvs_pkg::ST_DONE: begin
            // load the output register and clear the row
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_undef_in = undef_ff;
               if (undef_ff) result_in = '0;
               else if (take_root_ff) result_in = RESW'(root_ff);
               else result_in = quot_ff;
               sum_in = '0;
               sq_in  = '0;
            end
         end
         default: ;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rvs_pkg::ST_IDLE;
         count_ff     <= '0;
         sum_ff       <= '0;
         sq_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         step_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         sq_ff        <= sq_in;
         rsp_valid_ff <= rsp_valid_in;
         step_ff      <= step_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      n_ff         <= n_in;
      d_ff         <= d_in;
      undef_ff     <= undef_in;
      den_ff       <= den_in;
      acc_ff       <= acc_in;
      mcand_ff     <= mcand_in;
      mplier_ff    <= mplier_in;
      quot_ff      <= quot_in;
      rad_ff       <= rad_in;
      root_ff      <= root_in;
      result_ff    <= result_in;
      rsp_undef_ff <= rsp_undef_in;
   end

   // A row end stops intake while the sequencer runs
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && row_end) |=> !req_if.ready)
      else $error("intake open after row end");

   // An undefined result carries a zero value
   assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.undefined) |-> (rsp_if.result == '0))
      else $error("undefined result not zero");

   // Leaving the last state always presents an item
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == rvs_pkg::ST_DONE && state_in == rvs_pkg::ST_IDLE) |=> rsp_if.valid)
      else $error("finished row produced no item");

   // The divide never runs with a zero divisor
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == rvs_pkg::ST_DIV_CHK) |-> (den_ff != '0 && d_ff != '0))
      else $error("zero divisor reached divide");

endmodule

`default_nettype wire

>>> sim/testbench.sv
// Self-checking testbench for the row variance / standard deviation block.
`default_nettype none

module testbench;

   localparam int MAX_ROW   = rvs_pkg::DEFAULT_MAX_ROW_LENGTH;
   localparam int SAMPLE_W  = rvs_pkg::DEFAULT_SAMPLE_BITS;
   localparam int RES_W     = rvs_pkg::RESULT_BITS;
   localparam int LEN_W     = rvs_pkg::ROW_LENGTH_BITS;
   localparam int IDX_W     = rvs_pkg::CSR_INDEX_BITS;
   localparam int DATA_W    = rvs_pkg::CSR_DATA_BITS;
   localparam int SETTLE    = 160;        // row end to output register, with margin
   localparam int CYCLE_LIMIT = 1500000;
   localparam int RANDOM_ITEMS = 1100;

   typedef struct {
      logic [RES_W-1:0] value;
      logic             undef_flag;
   } row_result_type;

   // Running row statistics and the queue of row results still to come
   class row_board_type;
      logic              pop_mode;
      logic              root_mode;
      logic [LEN_W-1:0]  row_len;
      int unsigned       taken;
      logic [28:0]       sum;
      logic [42:0]       sq_sum;
      row_result_type    expected_rows[$];
      int unsigned       mismatches;

      function new();
         pop_mode    = rvs_pkg::POPULATION_MODE_RESET;
         root_mode   = rvs_pkg::TAKE_ROOT_RESET;
         row_len     = rvs_pkg::ROW_LENGTH_RESET;
         taken       = 0;
         sum         = '0;
         sq_sum      = '0;
         mismatches  = 0;
      endfunction

      function void set_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data);
         if (idx == rvs_pkg::CSR_POPULATION_MODE) begin
            pop_mode = data[0];
         end else if (idx == rvs_pkg::CSR_TAKE_ROOT) begin
            root_mode = data[0];
         end else if (idx == rvs_pkg::CSR_ROW_LENGTH) begin
            row_len = data[LEN_W-1:0];
         end
      endfunction

      function longint unsigned floor_root(longint unsigned v);
         longint unsigned r;
         longint unsigned t;
         r = 0;
         for (int b = rvs_pkg::ROOT_BITS - 1; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= v) r = t;
         end
         return r;
      endfunction

      function int pending();
         return expected_rows.size();
      endfunction

      // Accumulate one sample; close the row when the count reaches the length
      function void note_sample(logic signed [SAMPLE_W-1:0] s);
         int unsigned       eff;
         longint            signed_sum;
         longint unsigned   mag, n, a, b, num, den, q;
         row_result_type    r;
         eff = (row_len == 0) ? 1 : ((row_len > MAX_ROW) ? MAX_ROW : row_len);
         sum    = sum + 29'(longint'(s));
         sq_sum = sq_sum + 43'(longint'(s) * longint'(s));
         taken++;
         if (taken < eff) return;
         n = taken;
         if (!pop_mode && n == 1) begin
            r.value      = '0;
            r.undef_flag = 1'b1;
         end else begin
            signed_sum = longint'(signed'(sum));
            mag = (signed_sum < 0) ? -signed_sum : signed_sum;
            a   = n * longint'(sq_sum);
            b   = mag * mag;
            num = (a > b) ? (a - b) : 0;
            den = n * (pop_mode ? n : (n - 1));
            q   = num / den;
            if (q > rvs_pkg::RESULT_MAX) q = rvs_pkg::RESULT_MAX;
            if (root_mode) q = floor_root(q);
            r.value      = q[RES_W-1:0];
            r.undef_flag = 1'b0;
         end
         expected_rows.push_back(r);
         taken  = 0;
         sum    = '0;
         sq_sum = '0;
      endfunction

      function void check_row_result(logic [RES_W-1:0] value, logic undef_flag);
         row_result_type exp_r;
         if (expected_rows.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected row result: result=%0d undefined=%0b", value, undef_flag);
            return;
         end
         exp_r = expected_rows.pop_front();
         if (value !== exp_r.value || undef_flag !== exp_r.undef_flag) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"row result mismatch: expected result=%0d undefined=%0b, ",
                         "got result=%0d undefined=%0b"},
                        exp_r.value, exp_r.undef_flag, value, undef_flag);
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic csr_we;
   logic [IDX_W-1:0]  csr_index;
   logic [DATA_W-1:0] csr_data;
   bit   steady;
   int unsigned cycle_count = 0;
   row_board_type board;

   rvs_req_if #(.SAMPLE_BITS(SAMPLE_W)) req_ch ();
   rvs_rsp_if rsp_ch ();

   row_variance_stddev #(
      .MAX_ROW_LENGTH(MAX_ROW),
      .SAMPLE_BITS   (SAMPLE_W)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_if   (req_ch),
      .rsp_if   (rsp_ch),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_data (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Result side: stall at random, except in the steady stretch
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (steady) begin
         rsp_ch.ready <= 1'b1;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= 24);
      end
   end

   // Observe handshakes mid-cycle, where every signal is settled for the next edge
   always @(negedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) board.note_sample(req_ch.sample);
         if (rsp_ch.valid && rsp_ch.ready)
            board.check_row_result(rsp_ch.result, rsp_ch.undefined);
      end
   end

   task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
      while (!steady && $urandom_range(99) < 24) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.sample <= s;
      @(negedge clock);
      while (!req_ch.ready) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic write_reg(input logic [IDX_W-1:0] idx,
                            input logic [DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      board.set_reg(idx, data);
      @(posedge clock);
   endtask

   task automatic program_regs(input logic pm, input logic rt,
                               input logic [LEN_W-1:0] len);
      write_reg(rvs_pkg::CSR_POPULATION_MODE, DATA_W'(pm));
      write_reg(rvs_pkg::CSR_TAKE_ROOT, DATA_W'(rt));
      write_reg(rvs_pkg::CSR_ROW_LENGTH, DATA_W'(len));
      csr_we <= 1'b0;
   endtask

   // Drop valid, let every pending row come out, then let the sequencer settle
   task automatic close_phase();
      req_ch.valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   function automatic logic signed [SAMPLE_W-1:0] pick_sample();
      logic signed [SAMPLE_W-1:0] s;
      case ($urandom_range(3))
         0, 1: s = SAMPLE_W'($urandom);
         2: begin
            case ($urandom_range(3))
               0: s = 16'sh7FFF;
               1: s = 16'sh8000;
               2: s = 16'sh0000;
               default: s = 16'shFFFF;
            endcase
         end
         default: s = SAMPLE_W'($urandom_range(0, 511)) - 16'sd256;
      endcase
      return s;
   endfunction

   // One random configuration, a few whole rows, sometimes extra samples that can leave a partial row open
   task automatic run_random_phase(inout int unsigned sent);
      logic [LEN_W-1:0] len;
      int unsigned eff, rows, total;
      case ($urandom_range(9))
         0, 1, 2, 3, 4: len = LEN_W'($urandom_range(1, 8));
         5, 6:          len = LEN_W'($urandom_range(9, 40));
         7:             len = LEN_W'($urandom_range(41, 300));
         8:             len = LEN_W'($urandom_range(1, 2));
         default:       len = '0;
      endcase
      eff  = (len == '0) ? 1 : int'(len);
      rows = (eff > 40) ? 1 : $urandom_range(1, 5);
      total = rows * eff;
      if ($urandom_range(3) == 0) total += $urandom_range(1, eff);
      program_regs(1'($urandom_range(1)), 1'($urandom_range(1)), len);
      repeat (total) send_sample(pick_sample());
      sent += total;
      close_phase();
   endtask

   initial begin
      int unsigned random_sent;
      board           = new();
      reset           = 1'b1;
      steady          = 1'b0;
      csr_we          = 1'b0;
      csr_index       = '0;
      csr_data        = '0;
      req_ch.valid    = 1'b0;
      req_ch.sample   = '0;
      random_sent     = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Sample mode with one-sample rows: undefined division
      program_regs(1'b0, 1'b0, 13'd1);
      send_sample(16'sh7FFF);
      send_sample(16'sh8000);
      close_phase();

      // Population mode, one sample: zero variance
      program_regs(1'b1, 1'b0, 13'd1);
      send_sample(16'sh8000);
      close_phase();

      // Two-sample rows at the sample extremes, then a flat row
      program_regs(1'b0, 1'b0, 13'd2);
      send_sample(16'sh7FFF);
      send_sample(16'sh8000);
      send_sample(16'sh8000);
      send_sample(16'sh8000);
      close_phase();

      // Standard deviation at the extremes and near zero
      program_regs(1'b1, 1'b1, 13'd2);
      send_sample(16'sh7FFF);
      send_sample(16'sh8000);
      send_sample(16'sh0001);
      send_sample(16'sh0000);
      close_phase();

      program_regs(1'b0, 1'b1, 13'd3);
      send_sample(16'sh5555);
      send_sample(16'shFFFF);
      send_sample(16'sh2AAA);
      close_phase();

      // Row length zero behaves as one
      program_regs(1'b1, 1'b1, 13'd0);
      send_sample(16'sh1234);
      send_sample(16'shEDCB);
      close_phase();

      // Lower the row length below the count already taken
      program_regs(1'b1, 1'b0, 13'd8);
      repeat (5) send_sample(pick_sample());
      close_phase();
      program_regs(1'b1, 1'b0, 13'd3);
      send_sample(16'sh4000);
      close_phase();

      // Long row at full swing
      program_regs(1'b1, 1'b0, 13'd256);
      for (int i = 0; i < 256; i++) send_sample((i % 2) ? 16'sh8000 : 16'sh7FFF);
      close_phase();

      // A length above the maximum saturates, then a lower length ends the row
      program_regs(1'b0, 1'b1, 13'd4097);
      repeat (6) send_sample(pick_sample());
      close_phase();
      program_regs(1'b0, 1'b1, 13'd2);
      send_sample(16'sh0100);
      close_phase();

      // Random phases, with one stretch where neither side idles
      while (random_sent < RANDOM_ITEMS) begin
         steady = (random_sent >= 500 && random_sent < 800);
         run_random_phase(random_sent);
      end
      steady = 1'b0;

      close_phase();
      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

`default_nettype wire

>>> row_variance_stddev.f
design/rvs_pkg.sv
design/rvs_if.sv
design/row_variance_stddev.sv
sim/testbench.sv
